@@ rtl/xmbr_pkg.sv @@
// ----------------------------------------------------------------------------
// xmbr_pkg: shared types and constants of the block-transfer receiver
// Phase, result kind and link byte codes, the result descriptor passed from
// the protocol core to the output sequencer, and the CRC-16 byte update.
// ----------------------------------------------------------------------------
`default_nettype none

package xmbr_pkg;

    localparam int SECTOR_BYTES = 128;
    localparam logic [6:0] IDX_LAST = 7'(SECTOR_BYTES - 1);

    // configuration register indexes
    localparam logic REG_MAX_ERRORS   = 1'b0;
    localparam logic REG_CRC_ATTEMPTS = 1'b1;

    // link byte codes
    localparam logic [7:0] CH_SOH   = 8'h01;
    localparam logic [7:0] CH_EOT   = 8'h04;
    localparam logic [7:0] CH_ACK   = 8'h06;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_NAK   = 8'h15;
    localparam logic [7:0] CH_CAN   = 8'h18;
    localparam logic [7:0] CH_PROBE = 8'h43;

    localparam logic [15:0] CRC_POLY = 16'h1021;

    // discard reasons carried in the byte field
    localparam logic [7:0] DISC_DUP  = 8'h00;
    localparam logic [7:0] DISC_FAIL = 8'h01;

    // input functions
    localparam logic [1:0] FN_START   = 2'd0;
    localparam logic [1:0] FN_BYTE    = 2'd1;
    localparam logic [1:0] FN_TIMEOUT = 2'd2;

    // sequencer positions: A, B, nine CAN, nine BS, limit status
    localparam logic [4:0] POS_A        = 5'd0;
    localparam logic [4:0] POS_B        = 5'd1;
    localparam logic [4:0] POS_BS_FIRST = 5'd11;
    localparam logic [4:0] POS_LIMIT    = 5'd20;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_HAND,
        PH_HEAD,
        PH_JUNK,
        PH_BLK,
        PH_CMP,
        PH_DATA,
        PH_CRCH,
        PH_CHK
    } phase_t;

    typedef enum logic [2:0] {
        KIND_TX,
        KIND_DATA,
        KIND_COMMIT,
        KIND_DISCARD,
        KIND_DONE,
        KIND_CANCEL,
        KIND_HS_TIMEOUT,
        KIND_LIMIT
    } kind_t;

    // results of one input word: optional A, then optional B, then optional abort tail
    typedef struct packed {
        logic       a_valid;
        kind_t      a_kind;
        logic [7:0] a_byte;
        logic [7:0] a_blk;
        logic       b_valid;
        kind_t      b_kind;
        logic [7:0] b_byte;
        logic [7:0] b_blk;
        logic       tail;
    } desc_t;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc,
                                               input logic [7:0]  b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

@@ rtl/xmbr_core.sv @@
// ----------------------------------------------------------------------------
// xmbr_core: protocol core
// Input register, session state and one-pass step logic. Each input word
// updates the state and hands one result descriptor to the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module xmbr_core (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            cfg_wr_en,
    input  wire logic            cfg_index,
    input  wire logic [7:0]      cfg_wdata,
    input  wire logic            s_tvalid,
    output logic                 s_tready,
    input  wire logic [1:0]      s_func,
    input  wire logic [7:0]      s_byte,
    output logic                 desc_valid,
    output xmbr_pkg::desc_t      desc,
    input  wire logic            desc_ready
);

    logic       in_valid_reg, in_valid_next;
    logic [1:0] func_reg;
    logic [7:0] byte_reg;
    logic       fire;

    logic [7:0] max_errors_reg, crc_attempts_reg;

    xmbr_pkg::phase_t phase_reg, phase_next;
    logic [7:0]  error_count_reg, error_count_next;
    logic [7:0]  expected_reg, expected_next;
    logic        cancel_reg, cancel_next;
    logic        crc_mode_reg, crc_mode_next;
    logic [7:0]  hdr_blk_reg, hdr_blk_next;
    logic [7:0]  hdr_cmp_reg, hdr_cmp_next;
    logic [6:0]  idx_reg, idx_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  sum_reg, sum_next;
    logic [7:0]  crc_high_reg, crc_high_next;

    xmbr_pkg::desc_t desc_d;

    assign fire       = in_valid_reg && desc_ready;
    assign s_tready   = !in_valid_reg || desc_ready;
    assign desc_valid = fire;
    assign desc       = desc_d;

    always_comb begin
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
        if (s_tvalid && s_tready) begin
            func_reg <= s_func;
            byte_reg <= s_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_errors_reg   <= 8'd10;
            crc_attempts_reg <= 8'd5;
        end else if (cfg_wr_en) begin
            if (cfg_index == xmbr_pkg::REG_CRC_ATTEMPTS) begin
                crc_attempts_reg <= cfg_wdata;
            end else begin
                max_errors_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= xmbr_pkg::PH_IDLE;
            error_count_reg <= 8'd0;
            expected_reg    <= 8'd1;
            cancel_reg      <= 1'b0;
            crc_mode_reg    <= 1'b1;
            hdr_blk_reg     <= 8'd0;
            hdr_cmp_reg     <= 8'd0;
            idx_reg         <= 7'd0;
            crc_reg         <= 16'd0;
            sum_reg         <= 8'd0;
            crc_high_reg    <= 8'd0;
        end else if (fire) begin
            phase_reg       <= phase_next;
            error_count_reg <= error_count_next;
            expected_reg    <= expected_next;
            cancel_reg      <= cancel_next;
            crc_mode_reg    <= crc_mode_next;
            hdr_blk_reg     <= hdr_blk_next;
            hdr_cmp_reg     <= hdr_cmp_next;
            idx_reg         <= idx_next;
            crc_reg         <= crc_next;
            sum_reg         <= sum_next;
            crc_high_reg    <= crc_high_next;
        end
    end

    always_comb begin
        logic [7:0]  ec_inc;
        logic [7:0]  probe_ec;
        logic        do_probe;
        logic        do_nak;
        logic        do_hmiss;
        logic        ok;
        logic        begin_blk;

        ec_inc    = (error_count_reg == 8'hFF) ? 8'hFF : error_count_reg + 8'd1;
        probe_ec  = error_count_reg;
        do_probe  = 1'b0;
        do_nak    = 1'b0;
        do_hmiss  = 1'b0;
        ok        = 1'b0;
        begin_blk = 1'b0;

        phase_next       = phase_reg;
        error_count_next = error_count_reg;
        expected_next    = expected_reg;
        cancel_next      = cancel_reg;
        crc_mode_next    = crc_mode_reg;
        hdr_blk_next     = hdr_blk_reg;
        hdr_cmp_next     = hdr_cmp_reg;
        idx_next         = idx_reg;
        crc_next         = crc_reg;
        sum_next         = sum_reg;
        crc_high_next    = crc_high_reg;
        desc_d           = '0;

        unique case (func_reg)
            xmbr_pkg::FN_START: begin
                error_count_next = 8'd0;
                expected_next    = 8'd1;
                cancel_next      = 1'b0;
                hdr_blk_next     = 8'd0;
                hdr_cmp_next     = 8'd0;
                idx_next         = 7'd0;
                crc_next         = 16'd0;
                sum_next         = 8'd0;
                crc_high_next    = 8'd0;
                if (max_errors_reg == 8'd0) begin
                    desc_d.b_valid = 1'b1;
                    desc_d.b_kind  = xmbr_pkg::KIND_HS_TIMEOUT;
                    desc_d.b_blk   = 8'd1;
                    phase_next     = xmbr_pkg::PH_IDLE;
                end else begin
                    do_probe   = 1'b1;
                    probe_ec   = 8'd0;
                    phase_next = xmbr_pkg::PH_HAND;
                end
            end
            xmbr_pkg::FN_BYTE: begin
                unique case (phase_reg)
                    xmbr_pkg::PH_HAND: begin
                        if (byte_reg == xmbr_pkg::CH_SOH) begin
                            error_count_next = 8'd0;
                            cancel_next      = 1'b0;
                            begin_blk        = 1'b1;
                        end else if (byte_reg == xmbr_pkg::CH_CAN && cancel_reg) begin
                            desc_d.b_valid = 1'b1;
                            desc_d.b_kind  = xmbr_pkg::KIND_CANCEL;
                            desc_d.b_blk   = expected_reg;
                            phase_next     = xmbr_pkg::PH_IDLE;
                        end else begin
                            cancel_next = (byte_reg == xmbr_pkg::CH_CAN);
                            do_hmiss    = 1'b1;
                        end
                    end
                    xmbr_pkg::PH_HEAD: begin
                        if (byte_reg == xmbr_pkg::CH_CAN) begin
                            if (cancel_reg) begin
                                desc_d.b_valid = 1'b1;
                                desc_d.b_kind  = xmbr_pkg::KIND_CANCEL;
                                desc_d.b_blk   = expected_reg;
                                phase_next     = xmbr_pkg::PH_IDLE;
                            end else begin
                                cancel_next = 1'b1;
                            end
                        end else begin
                            cancel_next = 1'b0;
                            if (byte_reg == xmbr_pkg::CH_EOT) begin
                                desc_d.a_valid = 1'b1;
                                desc_d.a_kind  = xmbr_pkg::KIND_TX;
                                desc_d.a_byte  = xmbr_pkg::CH_ACK;
                                desc_d.a_blk   = expected_reg;
                                desc_d.b_valid = 1'b1;
                                desc_d.b_kind  = xmbr_pkg::KIND_DONE;
                                desc_d.b_blk   = expected_reg;
                                phase_next     = xmbr_pkg::PH_IDLE;
                            end else if (byte_reg == xmbr_pkg::CH_SOH) begin
                                begin_blk = 1'b1;
                            end else begin
                                phase_next = xmbr_pkg::PH_JUNK;
                            end
                        end
                    end
                    xmbr_pkg::PH_BLK: begin
                        hdr_blk_next = byte_reg;
                        phase_next   = xmbr_pkg::PH_CMP;
                    end
                    xmbr_pkg::PH_CMP: begin
                        hdr_cmp_next = byte_reg;
                        phase_next   = xmbr_pkg::PH_DATA;
                    end
                    xmbr_pkg::PH_DATA: begin
                        desc_d.b_valid = 1'b1;
                        desc_d.b_kind  = xmbr_pkg::KIND_DATA;
                        desc_d.b_byte  = byte_reg;
                        desc_d.b_blk   = hdr_blk_reg;
                        if (crc_mode_reg) begin
                            crc_next = xmbr_pkg::crc16_byte(crc_reg, byte_reg);
                        end else begin
                            sum_next = sum_reg + byte_reg;
                        end
                        if (idx_reg == xmbr_pkg::IDX_LAST) begin
                            idx_next   = 7'd0;
                            phase_next = crc_mode_reg ? xmbr_pkg::PH_CRCH
                                                      : xmbr_pkg::PH_CHK;
                        end else begin
                            idx_next = idx_reg + 7'd1;
                        end
                    end
                    xmbr_pkg::PH_CRCH: begin
                        crc_high_next = byte_reg;
                        phase_next    = xmbr_pkg::PH_CHK;
                    end
                    xmbr_pkg::PH_CHK: begin
                        ok = (hdr_blk_reg == expected_reg)
                          || (hdr_blk_reg == expected_reg - 8'd1);
                        if (hdr_cmp_reg != ~hdr_blk_reg) begin
                            ok = 1'b0;
                        end
                        if (crc_mode_reg) begin
                            if (crc_high_reg != crc_reg[15:8] || byte_reg != crc_reg[7:0]) begin
                                ok = 1'b0;
                            end
                        end else if (byte_reg != sum_reg) begin
                            ok = 1'b0;
                        end
                        desc_d.a_valid = 1'b1;
                        desc_d.a_kind  = xmbr_pkg::KIND_DISCARD;
                        desc_d.a_blk   = hdr_blk_reg;
                        if (!ok) begin
                            desc_d.a_byte = xmbr_pkg::DISC_FAIL;
                            do_nak        = 1'b1;
                        end else begin
                            if (hdr_blk_reg == expected_reg) begin
                                desc_d.a_kind = xmbr_pkg::KIND_COMMIT;
                            end
                            desc_d.a_byte    = xmbr_pkg::DISC_DUP;
                            expected_next    = hdr_blk_reg + 8'd1;
                            error_count_next = 8'd0;
                            desc_d.b_valid   = 1'b1;
                            desc_d.b_kind    = xmbr_pkg::KIND_TX;
                            desc_d.b_byte    = xmbr_pkg::CH_ACK;
                            desc_d.b_blk     = hdr_blk_reg + 8'd1;
                            phase_next       = xmbr_pkg::PH_HEAD;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            xmbr_pkg::FN_TIMEOUT: begin
                unique case (phase_reg)
                    xmbr_pkg::PH_HAND: begin
                        cancel_next = 1'b0;
                        do_hmiss    = 1'b1;
                    end
                    xmbr_pkg::PH_HEAD, xmbr_pkg::PH_JUNK: begin
                        cancel_next = 1'b0;
                        do_nak      = 1'b1;
                    end
                    xmbr_pkg::PH_BLK, xmbr_pkg::PH_CMP, xmbr_pkg::PH_DATA,
                    xmbr_pkg::PH_CRCH, xmbr_pkg::PH_CHK: begin
                        desc_d.a_valid = 1'b1;
                        desc_d.a_kind  = xmbr_pkg::KIND_DISCARD;
                        desc_d.a_byte  = xmbr_pkg::DISC_FAIL;
                        desc_d.a_blk   = hdr_blk_reg;
                        do_nak         = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase

        if (begin_blk) begin
            idx_next   = 7'd0;
            crc_next   = 16'd0;
            sum_next   = 8'd0;
            phase_next = xmbr_pkg::PH_BLK;
        end

        if (do_hmiss) begin
            error_count_next = ec_inc;
            if (ec_inc >= max_errors_reg) begin
                desc_d.b_valid = 1'b1;
                desc_d.b_kind  = xmbr_pkg::KIND_HS_TIMEOUT;
                desc_d.b_blk   = expected_reg;
                phase_next     = xmbr_pkg::PH_IDLE;
            end else begin
                do_probe = 1'b1;
                probe_ec = ec_inc;
            end
        end

        if (do_probe) begin
            desc_d.b_valid = 1'b1;
            desc_d.b_kind  = xmbr_pkg::KIND_TX;
            desc_d.b_blk   = expected_next;
            if (probe_ec < crc_attempts_reg) begin
                desc_d.b_byte = xmbr_pkg::CH_PROBE;
                crc_mode_next = 1'b1;
            end else begin
                desc_d.b_byte = xmbr_pkg::CH_NAK;
                crc_mode_next = 1'b0;
            end
        end

        if (do_nak) begin
            error_count_next = ec_inc;
            desc_d.b_valid   = 1'b1;
            desc_d.b_kind    = xmbr_pkg::KIND_TX;
            desc_d.b_byte    = xmbr_pkg::CH_NAK;
            desc_d.b_blk     = expected_reg;
            if (ec_inc >= max_errors_reg) begin
                desc_d.tail = 1'b1;
                phase_next  = xmbr_pkg::PH_IDLE;
            end else begin
                phase_next = xmbr_pkg::PH_HEAD;
            end
        end
    end

    // a word waiting on the sequencer holds in the input register
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !desc_ready |=> in_valid_reg && $stable(func_reg)
            && $stable(byte_reg))
        else $error("input register changed while stalled");

endmodule

`default_nettype wire

@@ rtl/xmbr_seq.sv @@
// ----------------------------------------------------------------------------
// xmbr_seq: result sequencer
// Expands one descriptor into its words in the output register, one per
// cycle unless m_ stalls, and takes the next as the final word is loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module xmbr_seq (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            desc_valid,
    input  wire xmbr_pkg::desc_t desc,
    output logic                 desc_ready,
    output logic                 m_tvalid,
    input  wire logic            m_tready,
    output logic [2:0]           m_kind,
    output logic [7:0]           m_byte,
    output logic [7:0]           m_blk,
    output logic                 m_last
);

    xmbr_pkg::desc_t desc_reg;
    logic            busy_reg, busy_next;
    logic [4:0]      pos_reg, pos_next;
    logic            m_tvalid_reg, m_tvalid_next;
    logic [2:0]      m_kind_reg;
    logic [7:0]      m_byte_reg, m_blk_reg;
    logic            m_last_reg;

    logic            load;
    logic            is_final;
    xmbr_pkg::kind_t item_kind;
    logic [7:0]      item_byte, item_blk;

    assign load       = busy_reg && (!m_tvalid_reg || m_tready);
    assign is_final   = (pos_reg == xmbr_pkg::POS_B && !desc_reg.tail)
                     || (pos_reg == xmbr_pkg::POS_LIMIT);
    assign desc_ready = !busy_reg || (load && is_final);

    always_comb begin
        priority if (pos_reg == xmbr_pkg::POS_A) begin
            item_kind = desc_reg.a_kind;
            item_byte = desc_reg.a_byte;
            item_blk  = desc_reg.a_blk;
        end else if (pos_reg == xmbr_pkg::POS_B) begin
            item_kind = desc_reg.b_kind;
            item_byte = desc_reg.b_byte;
            item_blk  = desc_reg.b_blk;
        end else if (pos_reg < xmbr_pkg::POS_BS_FIRST) begin
            item_kind = xmbr_pkg::KIND_TX;
            item_byte = xmbr_pkg::CH_CAN;
            item_blk  = desc_reg.b_blk;
        end else if (pos_reg < xmbr_pkg::POS_LIMIT) begin
            item_kind = xmbr_pkg::KIND_TX;
            item_byte = xmbr_pkg::CH_BS;
            item_blk  = desc_reg.b_blk;
        end else begin
            item_kind = xmbr_pkg::KIND_LIMIT;
            item_byte = 8'h00;
            item_blk  = desc_reg.b_blk;
        end
    end

    always_comb begin
        busy_next = busy_reg;
        pos_next  = pos_reg;
        if (desc_valid && desc_ready) begin
            busy_next = desc.b_valid;
            pos_next  = desc.a_valid ? xmbr_pkg::POS_A : xmbr_pkg::POS_B;
        end else if (load) begin
            if (is_final) begin
                busy_next = 1'b0;
            end else begin
                pos_next = pos_reg + 5'd1;
            end
        end
        if (load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            pos_reg      <= xmbr_pkg::POS_A;
            m_tvalid_reg <= 1'b0;
        end else begin
            busy_reg     <= busy_next;
            pos_reg      <= pos_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        if (desc_valid && desc_ready) begin
            desc_reg <= desc;
        end
        if (load) begin
            m_kind_reg <= item_kind;
            m_byte_reg <= item_byte;
            m_blk_reg  <= item_blk;
            m_last_reg <= is_final;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_kind   = m_kind_reg;
    assign m_byte   = m_byte_reg;
    assign m_blk    = m_blk_reg;
    assign m_last   = m_last_reg;

    a_tail_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && pos_reg > xmbr_pkg::POS_B |-> desc_reg.tail
            && pos_reg <= xmbr_pkg::POS_LIMIT)
        else $error("abort tail position without tail");

    a_last_mark: assert property (@(posedge aclk) disable iff (!aresetn)
        load && is_final |=> m_tvalid && m_last)
        else $error("final word not marked last");

    a_no_take_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && !load |-> !desc_ready)
        else $error("descriptor taken while words remain");

endmodule

`default_nettype wire

@@ rtl/xmodem_block_receiver.sv @@
// ----------------------------------------------------------------------------
// xmodem_block_receiver: receiver side of the block transfer protocol
// Input words are session start, a link byte or a receive timeout; output
// words are bytes to transmit, data bytes, block verdicts and status.
//
// s_ channel: tuser = func, tdata = received byte. One word is taken per
// cycle into an input register while s_tready is high; the next word is
// taken while the previous one's results are still queued, as long as the
// sequencer can take them. m_ channel: tuser = kind, tdata = byte and
// block number, tlast marks the final result of an input word. An input
// word yields 0 to 21 results, one word per cycle from a single output
// register while m_tready is high; a word with one result then sustains
// one per cycle. An accepted word goes through the input and descriptor
// registers to the output register, which a stalled m_ side holds; once
// the input register holds a word the sequencer cannot take, s_tready
// drops until the final word of a descriptor is loaded. Reset (aresetn
// low, synchronous) empties the input and output registers, returns the
// session to idle and loads the defaults (retry limit 10, five CRC probes).
// Config writes are taken at any edge with cfg_wr_en high, out of reset.
`default_nettype none

module xmodem_block_receiver (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_index,
    input  wire logic [7:0]  cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  wire logic [1:0]  s_tuser,   // [1:0] func
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [7:0] out_byte, [15:8] block_number
    output logic [2:0]       m_tuser,   // [2:0] out_kind
    output logic             m_tlast
);

    logic            desc_valid;
    logic            desc_ready;
    xmbr_pkg::desc_t desc;
    logic [7:0]      out_byte, out_blk;

    xmbr_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_func     (s_tuser),
        .s_byte     (s_tdata),
        .desc_valid (desc_valid),
        .desc       (desc),
        .desc_ready (desc_ready)
    );

    xmbr_seq u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .desc_valid (desc_valid),
        .desc       (desc),
        .desc_ready (desc_ready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_kind     (m_tuser),
        .m_byte     (out_byte),
        .m_blk      (out_blk),
        .m_last     (m_tlast)
    );

    assign m_tdata = {out_blk, out_byte};

endmodule

`default_nettype wire
